@@ hdl/deq_pkg.sv @@
// deq_pkg: operation, status and cell-mode codes for the double-ended queue
// no dependencies; used by the interfaces, the cells, the cell row and the top level
package deq_pkg;

   // request operation codes
   localparam logic [2:0] OP_INSERT_FRONT = 3'd0;
   localparam logic [2:0] OP_INSERT_END   = 3'd1;
   localparam logic [2:0] OP_DELETE_FRONT = 3'd2;
   localparam logic [2:0] OP_DELETE_END   = 3'd3;
   localparam logic [2:0] OP_DISPLAY      = 3'd4;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // per-cell update modes
   localparam logic [2:0] CELL_HOLD      = 3'd0;
   localparam logic [2:0] CELL_LOAD      = 3'd1;
   localparam logic [2:0] CELL_FROM_PREV = 3'd2;
   localparam logic [2:0] CELL_FROM_NEXT = 3'd3;
   localparam logic [2:0] CELL_FROM_HEAD = 3'd4;

   typedef logic signed [31:0] data_type;

   // control handed to each cell every cycle
   typedef struct packed {
      logic [2:0] mode;
      data_type   load_data;
   } cell_ctrl_type;

endpackage

@@ hdl/deq_if.sv @@
// deq_req_if / deq_rsp_if: valid-ready channels for requests and responses
// depends on deq_pkg
interface deq_req_if
   import deq_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   data_type   value_in;

   modport source (output valid, output operation, output value_in, input ready);
   modport sink   (input valid, input operation, input value_in, output ready);
endinterface

interface deq_rsp_if
   import deq_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [1:0] status;
   data_type   value_out;
   logic       last;

   modport source (output valid, output status, output value_out, output last, input ready);
   modport sink   (input valid, input status, input value_out, input last, output ready);
endinterface

@@ hdl/double_ended_queue_top.sv @@
// double_ended_queue_top: bounded deque kept as a row of shifting cells
// depends on deq_pkg, deq_if and deq_chain
// insert and delete: one request per cycle unless the response stalls; response registered the next cycle
// display of n entries: the request sets the busy flag, then each entry is registered
// into the response, one entry per cycle while the response is taken and the occupied slots
// rotate through the head slot; requests wait until the last entry is sent
// synchronous active-high reset empties the queue; slot contents are not cleared
module double_ended_queue_top
   import deq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic          clock,
   input  logic          reset,
   deq_req_if.sink       req_chan,
   deq_rsp_if.source     rsp_chan
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   data_type         rsp_value_ff, rsp_value_in;
   logic             rsp_last_ff, rsp_last_in;

   cell_ctrl_type    ctrl [CAPACITY];
   data_type         head_data;

   logic             out_free;
   logic             accept;
   logic             is_full;
   logic             is_empty;
   logic [CNT_W-1:0] tail_pos;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !busy_ff && out_free;
   assign accept = req_chan.valid && req_chan.ready;
   assign is_full = count_ff == CNT_W'(CAPACITY);
   assign is_empty = count_ff == '0;
   assign tail_pos = count_ff - CNT_W'(1);

   // request decode, cell control and response staging
   always_comb begin
      count_in      = count_ff;
      left_in       = left_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         ctrl[i].mode      = CELL_HOLD;
         ctrl[i].load_data = req_chan.value_in;
      end

      if (busy_ff) begin
         // display: send the head and rotate the occupied slots by one
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_value_in  = head_data;
            rsp_last_in   = left_ff == CNT_W'(1);
            left_in       = left_ff - CNT_W'(1);
            busy_in       = left_ff != CNT_W'(1);
            for (int i = 0; i < CAPACITY; i++) begin
               if (CNT_W'(i) < tail_pos) begin
                  ctrl[i].mode = CELL_FROM_NEXT;
               end else if (CNT_W'(i) == tail_pos) begin
                  ctrl[i].mode = CELL_FROM_HEAD;
               end
            end
         end
      end else if (accept) begin
         rsp_value_in = '0;
         rsp_last_in  = 1'b1;
         case (req_chan.operation)
            OP_INSERT_FRONT: begin
               rsp_valid_in = 1'b1;
               if (is_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in = ST_OK;
                  count_in      = count_ff + CNT_W'(1);
                  ctrl[0].mode  = CELL_LOAD;
                  for (int i = 1; i < CAPACITY; i++) begin
                     ctrl[i].mode = CELL_FROM_PREV;
                  end
               end
            end
            OP_INSERT_END: begin
               rsp_valid_in = 1'b1;
               if (is_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in = ST_OK;
                  count_in      = count_ff + CNT_W'(1);
                  for (int i = 0; i < CAPACITY; i++) begin
                     if (CNT_W'(i) == count_ff) begin
                        ctrl[i].mode = CELL_LOAD;
                     end
                  end
               end
            end
            OP_DELETE_FRONT: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_status_in = ST_OK;
                  count_in      = tail_pos;
                  for (int i = 0; i < CAPACITY; i++) begin
                     ctrl[i].mode = CELL_FROM_NEXT;
                  end
               end
            end
            OP_DELETE_END: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_status_in = ST_OK;
                  count_in      = tail_pos;
               end
            end
            OP_DISPLAY: begin
               if (is_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  busy_in = 1'b1;
                  left_in = count_ff;
               end
            end
            default: begin
               // unknown operation: dropped without a response
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         left_ff      <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         left_ff      <= left_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   deq_chain #(
      .CAPACITY (CAPACITY)
   ) u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .head_data (head_data)
   );

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.value_out = rsp_value_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

@@ hdl/deq_cell.sv @@
// deq_cell: one storage slot of the queue, fed by its neighbors, the head slot or a load value
// depends on deq_pkg
module deq_cell
   import deq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  data_type      prev_data,
   input  data_type      next_data,
   input  data_type      head_data,
   output data_type      data
);

   data_type data_ff;
   data_type data_in;

   // pick the new slot content
   always_comb begin
      case (ctrl.mode)
         CELL_LOAD:      data_in = ctrl.load_data;
         CELL_FROM_PREV: data_in = prev_data;
         CELL_FROM_NEXT: data_in = next_data;
         CELL_FROM_HEAD: data_in = head_data;
         default:        data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ hdl/deq_chain.sv @@
// deq_chain: row of deq_cell slots, slot 0 holds the front of the queue
// depends on deq_pkg and deq_cell
module deq_chain
   import deq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic          clock,
   input  cell_ctrl_type ctrl [CAPACITY],
   output data_type      head_data
);

   data_type cell_data [CAPACITY];

   // each slot sees its neighbors (zero past either end of the row) and the head slot
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      data_type prev_data;
      data_type next_data;

      if (i == 0) begin : g_first
         assign prev_data = '0;
      end else begin : g_mid_prev
         assign prev_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_data = '0;
      end else begin : g_mid_next
         assign next_data = cell_data[i+1];
      end

      deq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl[i]),
         .prev_data (prev_data),
         .next_data (next_data),
         .head_data (cell_data[0]),
         .data      (cell_data[i])
      );
   end

   assign head_data = cell_data[0];

endmodule
